@@ rtl/wpd_pkg.sv @@
// Shared types and constants for the windowed power presence detector.
// No dependencies; imported by every module in rtl/.
`timescale 1ns / 1ps

package wpd_pkg;

   localparam int SAMPLE_W        = 12;
   localparam int COUNT_W         = 16;
   localparam int HOLDOFF_W       = 16;
   localparam int STATE_W         = 2;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;
   localparam int WINDOW_SIZE_DEF = 16;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};
   localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};

   // Register reset values
   localparam logic [SAMPLE_W-1:0]  ON_THRESHOLD_RST  = 12'd3000;
   localparam logic [SAMPLE_W-1:0]  OFF_THRESHOLD_RST = 12'd2400;
   localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST       = 16'd10;
   localparam logic [SAMPLE_W-1:0]  RIPPLE_LIMIT_RST  = 12'd200;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ON_THRESHOLD  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFF_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLDOFF       = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIPPLE_LIMIT  = 2'd3;

   typedef enum logic [STATE_W-1:0] {
      PWR_UNKNOWN = 2'd0,
      PWR_OFF     = 2'd1,
      PWR_ON      = 2'd2
   } power_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_DONE
   } ctrl_state_type;

   // Control for the sample chain
   typedef struct packed {
      logic shift;   // every cell takes its neighbor's value
      logic load;    // head takes the new sample instead of the tail
   } win_ctrl_type;

endpackage

@@ rtl/wpd_cell.sv @@
// One window cell: holds a single sample and passes it on when shifted.
// Depends on wpd_pkg.
`timescale 1ns / 1ps

module wpd_cell
   import wpd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  logic [SAMPLE_W-1:0] sample_in,
   output logic [SAMPLE_W-1:0] sample_out
);

   logic [SAMPLE_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else if (shift) begin
         value_ff <= sample_in;
      end
   end

   assign sample_out = value_ff;

endmodule

@@ rtl/wpd_window.sv @@
// Sample window as a row of wpd_cell instances closed into a ring.
// Depends on wpd_pkg and wpd_cell.
`timescale 1ns / 1ps

module wpd_window
   import wpd_pkg::*;
#(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  win_ctrl_type        ctrl,
   input  logic [SAMPLE_W-1:0] sample_in,
   output logic [SAMPLE_W-1:0] tail
);

   logic [SAMPLE_W-1:0] link [WINDOW_SIZE+1];

   // Head takes a new sample on load, otherwise rotate the tail back around
   assign link[0] = ctrl.load ? sample_in : link[WINDOW_SIZE];

   for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
      wpd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (ctrl.shift),
         .sample_in  (link[i]),
         .sample_out (link[i+1])
      );
   end

   assign tail = link[WINDOW_SIZE];

endmodule

@@ rtl/wpd_divider.sv @@
// Division of the window sum by the window size: multiply by the rounded-up
// reciprocal, then keep the quotient bits above the shift. Depends on wpd_pkg.
`timescale 1ns / 1ps

module wpd_divider
   import wpd_pkg::*;
#(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [SAMPLE_W+$clog2(WINDOW_SIZE)-1:0] dividend,
   output logic                                   busy,
   output logic [SAMPLE_W-1:0]                    quotient
);

   localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_SIZE);
   // Reciprocal ceil(2^SHIFT / WINDOW_SIZE) is exact for every SUM_W-bit sum
   localparam int SHIFT   = SUM_W + $clog2(WINDOW_SIZE);
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << SHIFT) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

   logic                busy_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [SAMPLE_W-1:0] quo_ff;

   // Busy for the one cycle in which the product is turned into the quotient
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= PROD_W'(dividend) * PROD_W'(RECIP);
      end
      if (busy_ff) begin
         quo_ff <= prod_ff[SHIFT +: SAMPLE_W];
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/windowed_power_presence_detector_top.sv @@
// Top level of the windowed power presence detector.
// Depends on wpd_pkg, wpd_window, wpd_cell and wpd_divider.
`timescale 1ns / 1ps

// Each request transaction carries one 12-bit converter sample. The sample
// enters a window of WINDOW_SIZE cells (all zero after reset, oldest sample
// dropped), and one response transaction follows with the floor average of
// the window, the committed power state (unknown, off, on) after threshold
// hysteresis and hold-off, a flag for a freshly committed change, the window
// ripple (max minus min) and a quality flag against ripple_limit. The block
// works on one sample at a time: after a request is taken, the cell ring
// rotates once while sum, minimum and maximum build up at its tail, then a
// multiply by the reciprocal of the window size turns the sum into the
// average through launch, product and quotient steps, and the done state
// commits the state and loads the response register once that register is
// free. The next request is taken only after that load; the ring scan takes
// most of a sample's time. A response waiting for its consumer does not hold
// off the next request, only the commit of that next sample. Registers are
// to be written through the csr port only while no sample is in flight; the
// block itself does not enforce this. csr_ready is always high.

module windowed_power_presence_detector_top
   import wpd_pkg::*;
#(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_W-1:0]    req_sample,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_W-1:0]    rsp_average,
   output logic [STATE_W-1:0]     rsp_power_state,
   output logic                   rsp_power_on,
   output logic                   rsp_state_changed,
   output logic [SAMPLE_W-1:0]    rsp_ripple,
   output logic                   rsp_quality_good,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_SIZE);
   localparam int CNT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(WINDOW_SIZE - 1);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0]  on_thr_ff;
   logic [SAMPLE_W-1:0]  off_thr_ff;
   logic [HOLDOFF_W-1:0] holdoff_ff;
   logic [SAMPLE_W-1:0]  limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_thr_ff  <= ON_THRESHOLD_RST;
         off_thr_ff <= OFF_THRESHOLD_RST;
         holdoff_ff <= HOLDOFF_RST;
         limit_ff   <= RIPPLE_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ON_THRESHOLD:  on_thr_ff  <= csr_data[SAMPLE_W-1:0];
            CSR_OFF_THRESHOLD: off_thr_ff <= csr_data[SAMPLE_W-1:0];
            CSR_HOLDOFF:       holdoff_ff <= csr_data[HOLDOFF_W-1:0];
            CSR_RIPPLE_LIMIT:  limit_ff   <= csr_data[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Control state machine
   // ---------------------------------------------------------------------
   ctrl_state_type state_ff, state_in;
   logic           req_accept;
   logic           rsp_free;
   logic           rsp_load;
   logic           scan_en;
   logic           div_start;
   logic           div_busy;
   logic [CNT_W-1:0] scan_cnt_ff;
   win_ctrl_type   win_ctrl;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      scan_en   = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_en = 1'b1;
            if (scan_cnt_ff == SCAN_LAST) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the result until the response register is free
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sample ring: shift in on accept, rotate once during the scan
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0] tail;

   assign win_ctrl.shift = req_accept || scan_en;
   assign win_ctrl.load  = req_accept;

   wpd_window #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (win_ctrl),
      .sample_in (req_sample),
      .tail      (tail)
   );

   // ---------------------------------------------------------------------
   // Window statistics, built from the tail as the ring turns
   // ---------------------------------------------------------------------
   logic [SUM_W-1:0]    sum_ff;
   logic [SAMPLE_W-1:0] lo_ff;
   logic [SAMPLE_W-1:0] hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
      end else if (req_accept) begin
         scan_cnt_ff <= '0;
      end else if (scan_en) begin
         scan_cnt_ff <= scan_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sum_ff <= '0;
         lo_ff  <= SAMPLE_MAX;
         hi_ff  <= '0;
      end else if (scan_en) begin
         sum_ff <= sum_ff + SUM_W'(tail);
         if (tail < lo_ff) begin
            lo_ff <= tail;
         end
         if (tail > hi_ff) begin
            hi_ff <= tail;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Average = sum / WINDOW_SIZE
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0] average;

   wpd_divider #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .busy     (div_busy),
      .quotient (average)
   );

   // ---------------------------------------------------------------------
   // Hysteresis and hold-off
   // ---------------------------------------------------------------------
   power_state_type     committed_ff;
   power_state_type     want;
   power_state_type     next_state;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_inc;
   logic                commit;
   logic [SAMPLE_W-1:0] ripple;

   // hi never falls below lo once the whole window has been seen
   assign ripple    = hi_ff - lo_ff;
   assign count_inc = (count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      // on test wins when the thresholds overlap
      priority if (average >= on_thr_ff) begin
         want = PWR_ON;
      end else if (average <= off_thr_ff) begin
         want = PWR_OFF;
      end else begin
         want = committed_ff;
      end
      commit     = (HOLDOFF_W'(count_inc) >= holdoff_ff) && (want != committed_ff);
      next_state = commit ? want : committed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         committed_ff <= PWR_UNKNOWN;
         count_ff     <= '0;
      end else if (rsp_load) begin
         committed_ff <= next_state;
         count_ff     <= commit ? '0 : count_inc;
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_average_ff;
   logic [STATE_W-1:0]  rsp_state_ff;
   logic                rsp_changed_ff;
   logic [SAMPLE_W-1:0] rsp_ripple_ff;
   logic                rsp_quality_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_average_ff <= average;
         rsp_state_ff   <= next_state;
         rsp_changed_ff <= commit;
         rsp_ripple_ff  <= ripple;
         rsp_quality_ff <= (ripple <= limit_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_average       = rsp_average_ff;
   assign rsp_power_state   = rsp_state_ff;
   assign rsp_power_on      = (rsp_state_ff == PWR_ON);
   assign rsp_state_changed = rsp_changed_ff;
   assign rsp_ripple        = rsp_ripple_ff;
   assign rsp_quality_good  = rsp_quality_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // an accepted sample always starts the ring scan
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SCAN))
      else $error("accepted sample did not start the scan");

   // the divider runs only while the controller waits on it
   a_div_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == ST_DIVIDE))
      else $error("divider busy outside the divide phase");

   // a reported change leaves the hold-off count cleared
   a_change_clears_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_state_changed) |-> (count_ff == '0))
      else $error("state change reported with nonzero hold-off count");

   // a new transaction is never loaded over a stalled response
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !rsp_load)
      else $error("response register overwritten while stalled");

endmodule
